### design/adadelta_pkg.sv
package adadelta_pkg;

  // Field widths.
  localparam int GRAD_W    = 32;
  localparam int IDX_W     = 12;
  localparam int AVG_W     = 48;
  localparam int COEF_W    = 16;
  localparam int EPS_W     = 24;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 2;

  // Register indices on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_COMP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EPSILON    = 2'd2;

  // Register values after reset.
  localparam logic [COEF_W-1:0] DECAY_RST      = 16'd62259;
  localparam logic [COEF_W-1:0] DECAY_COMP_RST = 16'd3277;
  localparam logic [EPS_W-1:0]  EPSILON_RST    = 24'd1048576;

  // Iterative units: one result bit per stage.
  localparam int SQ_STEPS  = 32;
  localparam int DIV_STEPS = 32;

  // Pipeline stage positions.
  localparam int ST_A   = 0;
  localparam int ST_B   = 1;
  localparam int ST_C   = 2;
  localparam int ST_D   = 3;
  localparam int ST_E   = 4;
  localparam int ST_SQ0 = 5;
  localparam int ST_F   = ST_SQ0 + SQ_STEPS;
  localparam int ST_G   = ST_F + 1;
  localparam int ST_DV0 = ST_G + 1;
  localparam int ST_H   = ST_DV0 + DIV_STEPS;
  localparam int ST_I   = ST_H + 1;
  localparam int ST_J   = ST_I + 1;
  localparam int NST    = ST_J + 1;

  // A clamped average value and its saturation flag.
  typedef struct packed {
    logic             sat;
    logic [AVG_W-1:0] val;
  } sat_val_t;

  // State of the digit-by-digit square root.
  typedef struct packed {
    logic [63:0] x;
    logic [35:0] rem;
    logic [31:0] root;
  } sqrt_t;

  // State of the restoring divider.
  typedef struct packed {
    logic [32:0] rem;
    logic [31:0] q;
    logic [31:0] n;
  } quot_t;

  // Per-item control and sideband data that travels down the pipeline.
  typedef struct packed {
    logic             valid;
    logic             oor;
    logic             neg;
    logic             sat;
    logic             ovf;
    logic             zero;
    logic [IDX_W-1:0] idx;
    logic [31:0]      mag;
    logic [AVG_W-1:0] u_old;
  } side_t;

  // Square in Q16.48 to an average term in Q8.40, clamped.
  function automatic sat_val_t square_to_avg(input logic [63:0] sq);
    sat_val_t r;
    r.sat = |sq[63:56];
    r.val = r.sat ? '1 : sq[55:8];
    return r;
  endfunction

  // Sum of the two weighted terms, scaled back by 2^-16, clamped.
  function automatic sat_val_t blend_sum(input logic [63:0] p1, input logic [63:0] p2);
    logic [64:0] s;
    sat_val_t    r;
    s     = {1'b0, p1} + {1'b0, p2};
    r.sat = s[64];
    r.val = r.sat ? '1 : s[63:16];
    return r;
  endfunction

  // One result bit of the integer square root.
  function automatic sqrt_t sqrt_step(input sqrt_t s);
    logic [35:0] rem_sh;
    logic [35:0] trial;
    sqrt_t       r;
    rem_sh = {s.rem[33:0], s.x[63:62]};
    trial  = {2'b00, s.root, 2'b01};
    r.x    = {s.x[61:0], 2'b00};
    if (rem_sh >= trial) begin
      r.rem  = rem_sh - trial;
      r.root = {s.root[30:0], 1'b1};
    end else begin
      r.rem  = rem_sh;
      r.root = {s.root[30:0], 1'b0};
    end
    return r;
  endfunction

  // One quotient bit of the restoring division.
  function automatic quot_t quot_step(input quot_t s, input logic [31:0] d);
    logic [32:0] rem_sh;
    quot_t       r;
    rem_sh = {s.rem[31:0], s.n[31]};
    r.n    = {s.n[30:0], 1'b0};
    if (rem_sh >= {1'b0, d}) begin
      r.rem = rem_sh - {1'b0, d};
      r.q   = {s.q[30:0], 1'b1};
    end else begin
      r.rem = rem_sh;
      r.q   = {s.q[30:0], 1'b0};
    end
    return r;
  endfunction

endpackage

### design/adadelta_parameter_update_core.sv
// Channel    Direction  Handshake                 Payload
// in         request    in_valid_i / in_stall_o   grad_value_i, entry_index_i
// out        result     out_valid_o / out_stall_i step_value_o, clipped_o
// cfg        write      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One request is taken per cycle while in_stall_o is low.
// A request whose index matches one still in the pipeline waits until that one
// has written its update average back.
// After reset both average memories are swept to zero, one entry per cycle;
// no request is taken until the sweep is done.
// The output register has a skid stage behind it; the pipeline halts only once
// both are full.
module adadelta_parameter_update_core #(
  parameter int ENTRIES = 4096
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [adadelta_pkg::GRAD_W-1:0] grad_value_i,
  input  logic [adadelta_pkg::IDX_W-1:0]        entry_index_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [adadelta_pkg::GRAD_W-1:0] step_value_o,
  output logic                                  clipped_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [adadelta_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [adadelta_pkg::CFG_W-1:0]        cfg_data_i
);

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // Configuration registers.
  logic [adadelta_pkg::COEF_W-1:0] decay_q;
  logic [adadelta_pkg::COEF_W-1:0] dcomp_q;
  logic [adadelta_pkg::EPS_W-1:0]  eps_q;

  // Average memories and their read data.
  logic [adadelta_pkg::AVG_W-1:0] grad_mem [ENTRIES];
  logic [adadelta_pkg::AVG_W-1:0] upd_mem  [ENTRIES];
  logic [adadelta_pkg::AVG_W-1:0] rd_g_q;
  logic [adadelta_pkg::AVG_W-1:0] rd_u_q;
  logic [AW-1:0]                  rd_addr;

  // Clearing sweep after reset.
  logic          clr_busy_q;
  logic [AW-1:0] clr_cnt_q;

  // Memory write ports.
  logic                           g_we;
  logic [AW-1:0]                  g_waddr;
  logic [adadelta_pkg::AVG_W-1:0] g_wdata;
  logic                           u_we;
  logic [AW-1:0]                  u_waddr;
  logic [adadelta_pkg::AVG_W-1:0] u_wdata;

  // Pipeline control.
  adadelta_pkg::side_t side_q [adadelta_pkg::NST];
  adadelta_pkg::side_t side_d [adadelta_pkg::NST];
  logic en;
  logic hit;
  logic accept;

  // Stage payloads.
  logic [63:0]                    b_sq_q, b_sq_d;
  logic [adadelta_pkg::AVG_W-1:0] b_g_old_q;
  logic [63:0]                    c_p1_q, c_p1_d, c_p2_q, c_p2_d;
  adadelta_pkg::sat_val_t         c_fresh;
  adadelta_pkg::sat_val_t         d_avg;
  logic [adadelta_pkg::AVG_W-1:0] d_v_q;
  logic [63:0]                    e_xa_q, e_xa_d, e_xb_q, e_xb_d;
  adadelta_pkg::sqrt_t            sqa_q [adadelta_pkg::SQ_STEPS];
  adadelta_pkg::sqrt_t            sqa_d [adadelta_pkg::SQ_STEPS];
  adadelta_pkg::sqrt_t            sqb_q [adadelta_pkg::SQ_STEPS];
  adadelta_pkg::sqrt_t            sqb_d [adadelta_pkg::SQ_STEPS];
  logic [63:0]                    f_prod_q, f_prod_d;
  logic [31:0]                    f_d_q, f_d_d;
  adadelta_pkg::quot_t            g_quot_q, g_quot_d;
  logic [31:0]                    g_d_q;
  logic                           g_ovf;
  adadelta_pkg::quot_t            dv_q [adadelta_pkg::DIV_STEPS];
  adadelta_pkg::quot_t            dv_d [adadelta_pkg::DIV_STEPS];
  logic [31:0]                    dd_q [adadelta_pkg::DIV_STEPS];
  logic [31:0]                    dd_d [adadelta_pkg::DIV_STEPS];
  logic [31:0]                    h_limit;
  logic [31:0]                    h_m;
  logic                           h_sat;
  logic [63:0]                    i_sq_q, i_sq_d;
  adadelta_pkg::sat_val_t         j_fresh;
  logic [63:0]                    j_p1_q, j_p1_d, j_p2_q, j_p2_d;
  adadelta_pkg::sat_val_t         u_avg;

  // Result being emitted and the output register with its skid stage.
  logic        emit;
  logic [31:0] res_step;
  logic        res_clip;
  logic        out_valid_q, skid_valid_q;
  logic [31:0] out_step_q, skid_step_q;
  logic        out_clip_q, skid_clip_q;
  logic        out_take;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decay_q <= adadelta_pkg::DECAY_RST;
      dcomp_q <= adadelta_pkg::DECAY_COMP_RST;
      eps_q   <= adadelta_pkg::EPSILON_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        adadelta_pkg::CFG_DECAY:      decay_q <= cfg_data_i[adadelta_pkg::COEF_W-1:0];
        adadelta_pkg::CFG_DECAY_COMP: dcomp_q <= cfg_data_i[adadelta_pkg::COEF_W-1:0];
        adadelta_pkg::CFG_EPSILON:    eps_q   <= cfg_data_i[adadelta_pkg::EPS_W-1:0];
        default: ;
      endcase
    end
  end

  // Zeroing sweep over both memories after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      if (clr_cnt_q == AW'(ENTRIES - 1)) begin
        clr_busy_q <= 1'b0;
      end
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  // The pipeline halts only when the skid stage is occupied.
  assign en = !skid_valid_q;

  // An index still in flight must finish its write-back before it is read again.
  always_comb begin
    hit = 1'b0;
    for (int k = 0; k < adadelta_pkg::NST; k++) begin
      if (side_q[k].valid && (side_q[k].idx == entry_index_i)) begin
        hit = 1'b1;
      end
    end
  end

  assign in_stall_o = clr_busy_q || !en || hit;
  assign accept     = in_valid_i && !in_stall_o;
  assign rd_addr    = AW'(entry_index_i);

  // Write ports: the sweep, then the gradient average and the update average.
  assign g_we    = clr_busy_q ||
                   (en && side_q[adadelta_pkg::ST_C].valid && !side_q[adadelta_pkg::ST_C].oor);
  assign g_waddr = clr_busy_q ? clr_cnt_q : AW'(side_q[adadelta_pkg::ST_C].idx);
  assign g_wdata = clr_busy_q ? '0 : d_avg.val;
  assign u_we    = clr_busy_q ||
                   (en && side_q[adadelta_pkg::ST_J].valid && !side_q[adadelta_pkg::ST_J].oor);
  assign u_waddr = clr_busy_q ? clr_cnt_q : AW'(side_q[adadelta_pkg::ST_J].idx);
  assign u_wdata = clr_busy_q ? '0 : u_avg.val;

  always_ff @(posedge clk_i) begin
    if (g_we) begin
      grad_mem[g_waddr] <= g_wdata;
    end
    if (en) begin
      rd_g_q <= grad_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (u_we) begin
      upd_mem[u_waddr] <= u_wdata;
    end
    if (en) begin
      rd_u_q <= upd_mem[rd_addr];
    end
  end

  // Datapath of each stage.
  always_comb begin
    // Square of the gradient magnitude.
    b_sq_d = 64'(side_q[adadelta_pkg::ST_A].mag) * 64'(side_q[adadelta_pkg::ST_A].mag);

    // Weighted terms of the gradient average.
    c_fresh = adadelta_pkg::square_to_avg(b_sq_q);
    c_p1_d  = 64'(decay_q) * 64'(b_g_old_q);
    c_p2_d  = 64'(dcomp_q) * 64'(c_fresh.val);

    // New gradient average.
    d_avg = adadelta_pkg::blend_sum(c_p1_q, c_p2_q);

    // Root operands, scaled so that the roots come out in units of 2^-27.
    e_xa_d = {1'b0, 49'(side_q[adadelta_pkg::ST_D].u_old) + 49'(eps_q), 14'b0};
    e_xb_d = {1'b0, 49'(d_v_q) + 49'(eps_q), 14'b0};

    // Both square roots, one bit per stage.
    sqa_d[0] = adadelta_pkg::sqrt_step('{x: e_xa_q, rem: '0, root: '0});
    sqb_d[0] = adadelta_pkg::sqrt_step('{x: e_xb_q, rem: '0, root: '0});
    for (int j = 1; j < adadelta_pkg::SQ_STEPS; j++) begin
      sqa_d[j] = adadelta_pkg::sqrt_step(sqa_q[j-1]);
      sqb_d[j] = adadelta_pkg::sqrt_step(sqb_q[j-1]);
    end

    // Numerator of the update magnitude.
    f_prod_d = 64'(side_q[adadelta_pkg::ST_F-1].mag) *
               64'(sqa_q[adadelta_pkg::SQ_STEPS-1].root);
    f_d_d    = sqb_q[adadelta_pkg::SQ_STEPS-1].root;

    // A quotient of 2^32 or more is flagged here; the divider handles the rest.
    g_ovf        = (f_prod_q >= {f_d_q, 32'b0});
    g_quot_d.rem = {1'b0, f_prod_q[63:32]};
    g_quot_d.q   = '0;
    g_quot_d.n   = f_prod_q[31:0];

    // Division, one quotient bit per stage.
    dv_d[0] = adadelta_pkg::quot_step(g_quot_q, g_d_q);
    dd_d[0] = g_d_q;
    for (int j = 1; j < adadelta_pkg::DIV_STEPS; j++) begin
      dv_d[j] = adadelta_pkg::quot_step(dv_q[j-1], dd_q[j-1]);
      dd_d[j] = dd_q[j-1];
    end

    // Saturation of the update magnitude.
    h_limit = side_q[adadelta_pkg::ST_H-1].neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    if (side_q[adadelta_pkg::ST_H-1].zero) begin
      h_m   = '0;
      h_sat = 1'b0;
    end else if (side_q[adadelta_pkg::ST_H-1].ovf ||
                 (dv_q[adadelta_pkg::DIV_STEPS-1].q > h_limit)) begin
      h_m   = h_limit;
      h_sat = 1'b1;
    end else begin
      h_m   = dv_q[adadelta_pkg::DIV_STEPS-1].q;
      h_sat = 1'b0;
    end

    // Square of the update.
    i_sq_d = 64'(side_q[adadelta_pkg::ST_I-1].mag) * 64'(side_q[adadelta_pkg::ST_I-1].mag);

    // Weighted terms of the update average.
    j_fresh = adadelta_pkg::square_to_avg(i_sq_q);
    j_p1_d  = 64'(decay_q) * 64'(side_q[adadelta_pkg::ST_J-1].u_old);
    j_p2_d  = 64'(dcomp_q) * 64'(j_fresh.val);

    // New update average and the result.
    u_avg = adadelta_pkg::blend_sum(j_p1_q, j_p2_q);
    if (side_q[adadelta_pkg::ST_J].oor) begin
      res_step = '0;
      res_clip = 1'b0;
    end else begin
      res_step = side_q[adadelta_pkg::ST_J].neg ? (~side_q[adadelta_pkg::ST_J].mag + 32'd1)
                                                : side_q[adadelta_pkg::ST_J].mag;
      res_clip = side_q[adadelta_pkg::ST_J].sat | u_avg.sat;
    end
  end

  // Sideband moves one stage per cycle while the pipeline is not halted, picking up flags on the way.
  always_comb begin
    side_d[0].valid = accept;
    side_d[0].oor   = (32'(entry_index_i) >= 32'(ENTRIES));
    side_d[0].neg   = grad_value_i[adadelta_pkg::GRAD_W-1];
    side_d[0].sat   = 1'b0;
    side_d[0].ovf   = 1'b0;
    side_d[0].zero  = 1'b0;
    side_d[0].idx   = entry_index_i;
    side_d[0].mag   = grad_value_i[adadelta_pkg::GRAD_W-1] ?
                      (~grad_value_i + 32'd1) : grad_value_i;
    side_d[0].u_old = '0;
    for (int k = 1; k < adadelta_pkg::NST; k++) begin
      side_d[k] = side_q[k-1];
    end
    side_d[adadelta_pkg::ST_B].u_old = rd_u_q;
    side_d[adadelta_pkg::ST_C].sat   = side_q[adadelta_pkg::ST_B].sat | c_fresh.sat;
    side_d[adadelta_pkg::ST_D].sat   = side_q[adadelta_pkg::ST_C].sat | d_avg.sat;
    side_d[adadelta_pkg::ST_G].ovf   = g_ovf;
    side_d[adadelta_pkg::ST_G].zero  = (f_d_q == '0);
    side_d[adadelta_pkg::ST_H].mag   = h_m;
    side_d[adadelta_pkg::ST_H].sat   = side_q[adadelta_pkg::ST_H-1].sat | h_sat;
    side_d[adadelta_pkg::ST_J].sat   = side_q[adadelta_pkg::ST_J-1].sat | j_fresh.sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= '{default: '0};
    end else if (en) begin
      side_q <= side_d;
    end
  end

  // Stage payload registers.
  always_ff @(posedge clk_i) begin
    if (en) begin
      b_sq_q    <= b_sq_d;
      b_g_old_q <= rd_g_q;
      c_p1_q    <= c_p1_d;
      c_p2_q    <= c_p2_d;
      d_v_q     <= d_avg.val;
      e_xa_q    <= e_xa_d;
      e_xb_q    <= e_xb_d;
      sqa_q     <= sqa_d;
      sqb_q     <= sqb_d;
      f_prod_q  <= f_prod_d;
      f_d_q     <= f_d_d;
      g_quot_q  <= g_quot_d;
      g_d_q     <= f_d_q;
      dv_q      <= dv_d;
      dd_q      <= dd_d;
      i_sq_q    <= i_sq_d;
      j_p1_q    <= j_p1_d;
      j_p2_q    <= j_p2_d;
    end
  end

  // Output register with a skid stage behind it.
  assign emit     = en && side_q[adadelta_pkg::ST_J].valid;
  assign out_take = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (emit) begin
      if (!out_valid_q || out_take) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_step_q <= skid_step_q;
        out_clip_q <= skid_clip_q;
      end
    end else if (emit) begin
      if (!out_valid_q || out_take) begin
        out_step_q <= res_step;
        out_clip_q <= res_clip;
      end else begin
        skid_step_q <= res_step;
        skid_clip_q <= res_clip;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign step_value_o = out_step_q;
  assign clipped_o    = out_clip_q;

endmodule
